// File: hw/rtl/tse_pkg.sv
// tse_pkg: shared types and constants of the tls server-name extractor
// no dependencies; imported by every module of the block
package tse_pkg;

   localparam int TSE_PACKET_CAP = 16384;
   localparam int TSE_QUEUE_DEPTH = 4;
   localparam logic [10:0] TSE_CAP_RESET = 11'd256;
   localparam logic [10:0] TSE_CAP_MAX = 11'd1024;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_TRUNC = 2'd1;
   localparam logic [1:0] ST_MAL   = 2'd2;
   localparam logic [1:0] ST_UNSUP = 2'd3;

   localparam logic KIND_NAME   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   typedef struct packed {
      logic [7:0] pkt_byte;
      logic       end_of_packet;
   } tse_req_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] name_byte;
      logic [9:0] name_index;
      logic [1:0] status;
      logic [9:0] name_length;
      logic       last_of_run;
   } tse_rsp_type;

   // one front-end event: an optional hostname byte and an optional status
   typedef struct packed {
      logic       has_name;
      logic       has_status;
      logic [7:0] name_byte;
      logic [9:0] name_index;
      logic [1:0] status;
      logic [9:0] name_length;
   } tse_evt_type;

endpackage

// File: hw/rtl/tse_front.sv
// tse_front: per-byte client hello parser, one packet byte per cycle while take is high
// depends on tse_pkg; feeds events into tse_queue
module tse_front #(
   parameter int PacketCap = tse_pkg::TSE_PACKET_CAP
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [10:0]          csr_wr_data,
   input  logic                 take,
   input  tse_pkg::tse_req_type req,
   output logic                 evt_push,
   output tse_pkg::tse_evt_type evt
);
   import tse_pkg::*;

   localparam logic [3:0] PH_HEAD    = 4'd0;
   localparam logic [3:0] PH_SESSLEN = 4'd1;
   localparam logic [3:0] PH_SESS    = 4'd2;
   localparam logic [3:0] PH_CIPHLEN = 4'd3;
   localparam logic [3:0] PH_CIPH    = 4'd4;
   localparam logic [3:0] PH_COMPLEN = 4'd5;
   localparam logic [3:0] PH_COMP    = 4'd6;
   localparam logic [3:0] PH_EXTSLEN = 4'd7;
   localparam logic [3:0] PH_EXTHDR  = 4'd8;
   localparam logic [3:0] PH_EXTSKIP = 4'd9;
   localparam logic [3:0] PH_SNIHDR  = 4'd10;
   localparam logic [3:0] PH_NAME    = 4'd11;
   localparam logic [3:0] PH_DONE    = 4'd12;

   localparam logic [14:0] CapW = 15'(PacketCap);

   logic [10:0] host_cap_ff;
   logic [14:0] byte_cnt_ff, byte_cnt_in;
   logic [3:0]  phase_ff, phase_in;
   logic [15:0] rem_ff, rem_in;
   logic [23:0] acc_ff, acc_in;
   logic [16:0] ext_end_ff, ext_end_in;
   logic [15:0] ext_type_ff, ext_type_in;
   logic [15:0] ext_len_ff, ext_len_in;
   logic [15:0] host_len_ff, host_len_in;
   logic [1:0]  pend_ff, pend_in;
   logic [16:0] needs_ff, needs_in;
   logic        sni_ff, sni_in;

   logic [7:0]  b;
   logic [14:0] pos;
   logic [16:0] pos_p1;
   logic [15:0] acc16;
   logic [23:0] acc24;
   logic [15:0] rem_dec;
   logic [10:0] cap;
   logic [16:0] new_end;
   logic        name_hit;
   logic [9:0]  name_idx;
   logic [1:0]  st;

   always_ff @(posedge clock) begin
      if (reset) begin
         host_cap_ff <= TSE_CAP_RESET;
      end else if (csr_wr_en) begin
         host_cap_ff <= csr_wr_data;
      end
   end

   always_comb begin
      b       = req.pkt_byte;
      pos     = byte_cnt_ff;
      pos_p1  = {2'b0, pos} + 17'd1;
      acc16   = {acc_ff[7:0], b};
      acc24   = {acc_ff[15:0], b};
      rem_dec = rem_ff - 16'd1;
      cap     = (host_cap_ff > TSE_CAP_MAX) ? TSE_CAP_MAX : host_cap_ff;
      new_end = pos_p1 + {1'b0, acc16};

      byte_cnt_in = byte_cnt_ff;
      phase_in    = phase_ff;
      rem_in      = rem_ff;
      acc_in      = acc_ff;
      ext_end_in  = ext_end_ff;
      ext_type_in = ext_type_ff;
      ext_len_in  = ext_len_ff;
      host_len_in = host_len_ff;
      pend_in     = pend_ff;
      needs_in    = needs_ff;
      sni_in      = sni_ff;
      name_hit    = 1'b0;
      name_idx    = '0;
      st          = ST_OK;

      if (pos < CapW && phase_ff != PH_DONE) begin
         unique case (phase_ff) inside
            PH_HEAD: begin
               if (pos == 15'd0 && b != 8'h16) begin
                  phase_in = PH_DONE; pend_in = ST_UNSUP; needs_in = 17'd5;
               end else if (pos == 15'd5 && b != 8'h01) begin
                  phase_in = PH_DONE; pend_in = ST_UNSUP; needs_in = 17'd9;
               end else if (pos >= 15'd6 && pos <= 15'd8) begin
                  acc_in = acc24;
                  if (pos == 15'd8 && acc24 > {9'b0, CapW}) begin
                     phase_in = PH_DONE; pend_in = ST_MAL; needs_in = 17'd9;
                  end
               end else if (pos == 15'd42) begin
                  phase_in = PH_SESSLEN; rem_in = 16'd1; acc_in = '0;
               end
            end
            PH_SESSLEN: begin
               acc_in = '0;
               if (b == 8'd0) begin
                  phase_in = PH_CIPHLEN; rem_in = 16'd2;
               end else begin
                  phase_in = PH_SESS; rem_in = {8'b0, b};
               end
            end
            PH_SESS, PH_CIPH, PH_COMP: begin
               rem_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  acc_in = '0;
                  if (phase_ff == PH_SESS) begin
                     phase_in = PH_CIPHLEN; rem_in = 16'd2;
                  end else if (phase_ff == PH_CIPH) begin
                     phase_in = PH_COMPLEN; rem_in = 16'd1;
                  end else begin
                     phase_in = PH_EXTSLEN; rem_in = 16'd2;
                  end
               end
            end
            PH_CIPHLEN: begin
               acc_in = {8'b0, acc16};
               rem_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  acc_in = '0;
                  if (acc16 == 16'd0) begin
                     phase_in = PH_COMPLEN; rem_in = 16'd1;
                  end else begin
                     phase_in = PH_CIPH; rem_in = acc16;
                  end
               end
            end
            PH_COMPLEN: begin
               acc_in = '0;
               if (b == 8'd0) begin
                  phase_in = PH_EXTSLEN; rem_in = 16'd2;
               end else begin
                  phase_in = PH_COMP; rem_in = {8'b0, b};
               end
            end
            PH_EXTSLEN: begin
               acc_in = {8'b0, acc16};
               rem_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  if (acc16 > {1'b0, CapW}) begin
                     phase_in = PH_DONE; pend_in = ST_MAL; needs_in = pos_p1;
                  end else begin
                     ext_end_in = new_end;
                     if (pos_p1 + 17'd4 <= new_end) begin
                        phase_in = PH_EXTHDR; rem_in = 16'd4; acc_in = '0;
                     end else begin
                        phase_in = PH_DONE; pend_in = ST_UNSUP; needs_in = new_end;
                     end
                  end
               end
            end
            PH_EXTHDR: begin
               acc_in = {8'b0, acc16};
               rem_in = rem_dec;
               if (rem_dec == 16'd2) begin
                  ext_type_in = acc16;
                  acc_in = '0;
               end else if (rem_dec == 16'd0) begin
                  ext_len_in = acc16;
                  if ({1'b0, pos_p1} + {2'b0, acc16} > {1'b0, ext_end_ff}) begin
                     phase_in = PH_DONE; pend_in = ST_MAL; needs_in = ext_end_ff;
                  end else if (ext_type_ff == 16'h0000) begin
                     if (acc16 < 16'd5) begin
                        phase_in = PH_DONE; pend_in = ST_MAL; needs_in = ext_end_ff;
                     end else begin
                        phase_in = PH_SNIHDR; rem_in = 16'd5; acc_in = '0;
                     end
                  end else if (acc16 == 16'd0) begin
                     if (pos_p1 + 17'd4 <= ext_end_ff) begin
                        phase_in = PH_EXTHDR; rem_in = 16'd4; acc_in = '0;
                     end else begin
                        phase_in = PH_DONE; pend_in = ST_UNSUP; needs_in = ext_end_ff;
                     end
                  end else begin
                     phase_in = PH_EXTSKIP; rem_in = acc16; acc_in = '0;
                  end
               end
            end
            PH_EXTSKIP: begin
               rem_in = rem_dec;
               if (rem_dec == 16'd0) begin
                  if (pos_p1 + 17'd4 <= ext_end_ff) begin
                     phase_in = PH_EXTHDR; rem_in = 16'd4; acc_in = '0;
                  end else begin
                     phase_in = PH_DONE; pend_in = ST_UNSUP; needs_in = ext_end_ff;
                  end
               end
            end
            PH_SNIHDR: begin
               // third header byte is the name type, must be host_name
               if (rem_ff == 16'd3 && b != 8'h00) begin
                  phase_in = PH_DONE; pend_in = ST_MAL; needs_in = ext_end_ff;
               end else begin
                  acc_in = {8'b0, acc16};
                  rem_in = rem_dec;
                  if (rem_dec == 16'd0) begin
                     if (17'd5 + {1'b0, acc16} > {1'b0, ext_len_ff} || acc16 == 16'd0
                         || acc16 >= {5'b0, cap}) begin
                        phase_in = PH_DONE; pend_in = ST_MAL; needs_in = ext_end_ff;
                     end else begin
                        host_len_in = acc16;
                        phase_in = PH_NAME; rem_in = acc16; acc_in = '0;
                     end
                  end
               end
            end
            PH_NAME: begin
               name_hit = 1'b1;
               name_idx = 10'(host_len_ff - rem_ff);
               rem_in   = rem_dec;
               if (rem_dec == 16'd0) begin
                  sni_in = 1'b1;
                  phase_in = PH_DONE; pend_in = ST_OK; needs_in = ext_end_ff;
               end
            end
            default: begin
            end
         endcase
      end

      if (byte_cnt_ff <= CapW) begin
         byte_cnt_in = byte_cnt_ff + 15'd1;
      end

      if (host_cap_ff == 11'd0 || byte_cnt_in > CapW) begin
         st = ST_MAL;
      end else if (phase_in == PH_DONE && {2'b0, byte_cnt_in} >= needs_in) begin
         st = pend_in;
      end else begin
         st = ST_TRUNC;
      end

      evt.has_name    = name_hit;
      evt.has_status  = req.end_of_packet;
      evt.name_byte   = name_hit ? b : 8'd0;
      evt.name_index  = name_idx;
      evt.status      = st;
      evt.name_length = (st == ST_OK && sni_in) ? host_len_in[9:0] : 10'd0;
      evt_push        = take && (name_hit || req.end_of_packet);

      if (req.end_of_packet) begin
         byte_cnt_in = '0;
         phase_in    = PH_HEAD;
         rem_in      = '0;
         acc_in      = '0;
         ext_end_in  = '0;
         ext_type_in = '0;
         ext_len_in  = '0;
         host_len_in = '0;
         pend_in     = ST_OK;
         needs_in    = '0;
         sni_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_cnt_ff <= '0;
         phase_ff    <= PH_HEAD;
         rem_ff      <= '0;
         acc_ff      <= '0;
         ext_end_ff  <= '0;
         ext_type_ff <= '0;
         ext_len_ff  <= '0;
         host_len_ff <= '0;
         pend_ff     <= ST_OK;
         needs_ff    <= '0;
         sni_ff      <= 1'b0;
      end else if (take) begin
         byte_cnt_ff <= byte_cnt_in;
         phase_ff    <= phase_in;
         rem_ff      <= rem_in;
         acc_ff      <= acc_in;
         ext_end_ff  <= ext_end_in;
         ext_type_ff <= ext_type_in;
         ext_len_ff  <= ext_len_in;
         host_len_ff <= host_len_in;
         pend_ff     <= pend_in;
         needs_ff    <= needs_in;
         sni_ff      <= sni_in;
      end
   end

endmodule

// File: hw/rtl/tse_queue.sv
// tse_queue: small event queue between parser and result stage
// depends on tse_pkg
module tse_queue #(
   parameter int Depth = tse_pkg::TSE_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tse_pkg::tse_evt_type evt_in,
   input  logic                 pop,
   output tse_pkg::tse_evt_type evt_out,
   output logic                 empty,
   output logic                 full
);
   import tse_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tse_evt_type          slot_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]      count_ff;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CntW'(Depth));
   assign evt_out = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= evt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

// File: hw/rtl/tse_back.sv
// tse_back: splits queued events into result items behind an output register
// depends on tse_pkg; reads from tse_queue
module tse_back (
   input  logic                 clock,
   input  logic                 reset,
   input  tse_pkg::tse_evt_type evt,
   input  logic                 empty,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tse_pkg::tse_rsp_type rsp_data
);
   import tse_pkg::*;

   logic        valid_ff, valid_in;
   tse_rsp_type data_ff, data_in;
   logic        half_ff, half_in;
   logic        load;
   logic        both;

   always_comb begin
      load = !empty && (!valid_ff || !rsp_stall);
      both = evt.has_name && evt.has_status;
      valid_in = valid_ff && rsp_stall;
      data_in  = data_ff;
      half_in  = half_ff;
      pop      = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (evt.has_name && !half_ff) begin
            data_in.kind        = KIND_NAME;
            data_in.name_byte   = evt.name_byte;
            data_in.name_index  = evt.name_index;
            data_in.status      = ST_OK;
            data_in.name_length = '0;
            data_in.last_of_run = !evt.has_status;
         end else begin
            data_in.kind        = KIND_STATUS;
            data_in.name_byte   = '0;
            data_in.name_index  = '0;
            data_in.status      = evt.status;
            data_in.name_length = evt.name_length;
            data_in.last_of_run = 1'b1;
         end
         if (both && !half_ff) begin
            half_in = 1'b1;
         end else begin
            half_in = 1'b0;
            pop     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         half_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         half_ff  <= half_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// File: hw/rtl/tls_sni_extractor.sv
// tls_sni_extractor: top level of the streaming client hello server-name extractor
// depends on tse_pkg, tse_front, tse_queue, tse_back
//
//   channel   direction   handshake            payload
//   req_      in          req_valid/req_stall  tse_req_type (pkt_byte, end_of_packet)
//   rsp_      out         rsp_valid/rsp_stall  tse_rsp_type (kind .. last_of_run)
//   csr_      in          csr_wr_en            csr_wr_data, host capacity (11 bits)
//
// one packet byte is taken per cycle whenever the event queue has room
// a byte that both carries a hostname byte and ends the packet gives two
// results, which the output stage sends one after the other, the name item first
// results pass through the queue and then the output register before they appear
// reset is synchronous and clears parser, queue and output valid
// rsp_stall only fills the queue; req_stall rises once it holds four events
module tls_sni_extractor #(
   parameter int PacketCap = tse_pkg::TSE_PACKET_CAP
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tse_pkg::tse_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tse_pkg::tse_rsp_type rsp_data,
   input  logic                 csr_wr_en,
   input  logic [10:0]          csr_wr_data
);
   import tse_pkg::*;

   logic        take;
   logic        evt_push;
   tse_evt_type evt_front;
   tse_evt_type evt_head;
   logic        q_empty;
   logic        q_full;
   logic        q_pop;

   // stall depends only on the registered queue fill
   assign req_stall = q_full;
   assign take      = req_valid && !req_stall;

   // parser: classifies each byte and decides the per-packet status
   tse_front #(
      .PacketCap(PacketCap)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .take       (take),
      .req        (req_data),
      .evt_push   (evt_push),
      .evt        (evt_front)
   );

   // decouples parser from the result side
   tse_queue #(
      .Depth(TSE_QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (evt_push),
      .evt_in (evt_front),
      .pop    (q_pop),
      .evt_out(evt_head),
      .empty  (q_empty),
      .full   (q_full)
   );

   // result stage: one or two items per event
   tse_back u_back (
      .clock    (clock),
      .reset    (reset),
      .evt      (evt_head),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule

// File: hw/rtl/tse_checker.sv
// tse_checker: port-level assertions for tls_sni_extractor
// depends on tse_pkg; bound to the top level below
module tse_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input tse_pkg::tse_rsp_type rsp_data
);
   import tse_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // a status item always closes its input's results
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_STATUS |-> rsp_data.last_of_run)
      else $error("status item not last of run");

   // hostname items carry no status and no length
   a_name_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind == KIND_NAME |->
         rsp_data.status == ST_OK && rsp_data.name_length == 10'd0)
      else $error("hostname item with status fields");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind tls_sni_extractor tse_checker u_tse_checker (
   .clock    (clock),
   .reset    (reset),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);

// File: dv/tls_sni_extractor_tb.sv
// tls_sni_extractor_tb: self-checking testbench for the tls server-name extractor
// depends on tse_pkg and the tls_sni_extractor rtl; streams client hello packets,
// predicts every hostname byte and status, and compares results as they leave
`timescale 1ns / 100ps

module tls_sni_extractor_tb;
   import tse_pkg::*;

   // parser phases of the predictor, in packet order
   typedef enum int unsigned {
      PH_HEAD, PH_SESSLEN, PH_SESS, PH_CIPHLEN, PH_CIPH, PH_COMPLEN, PH_COMP,
      PH_EXTSLEN, PH_EXTHDR, PH_EXTSKIP, PH_SNIHDR, PH_NAME, PH_DONE
   } hello_phase_type;

   localparam int unsigned SNI_EXT_TYPE = 16'h0000;
   localparam logic [7:0] REC_HANDSHAKE = 8'h16;
   localparam logic [7:0] HS_CLIENT_HELLO = 8'h01;
   localparam logic [7:0] NAME_TYPE_HOST = 8'h00;

   // predictor of the extractor plus the queue of results it owes
   class sni_scoreboard_type;
      int unsigned  capacity;
      int unsigned  byte_count, remain, acc, ext_end, ext_type, ext_len, host_len;
      int unsigned  err_needs;
      logic [1:0]   err_code;
      bit           name_seen;
      hello_phase_type phase;
      tse_rsp_type  owed_q[$];
      int           fails;
      int           checked;

      function new();
         capacity = TSE_CAP_RESET;
         fails = 0;
         checked = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         byte_count = 0;
         phase = PH_HEAD;
         remain = 0;
         acc = 0;
         ext_end = 0;
         ext_type = 0;
         ext_len = 0;
         host_len = 0;
         err_code = ST_OK;
         err_needs = 0;
         name_seen = 0;
      endfunction

      function void settle(logic [1:0] code, int unsigned needs);
         phase = PH_DONE;
         err_code = code;
         err_needs = needs;
      endfunction

      function void open_field(hello_phase_type ph, int unsigned n);
         phase = ph;
         remain = n;
         acc = 0;
      endfunction

      function void next_ext(int unsigned next_pos);
         if (next_pos + 4 <= ext_end) open_field(PH_EXTHDR, 4);
         else settle(ST_UNSUP, ext_end);
      endfunction

      function void skip_or(int unsigned len, hello_phase_type skip_ph,
                            hello_phase_type next_ph, int unsigned n);
         if (len == 0) open_field(next_ph, n);
         else open_field(skip_ph, len);
      endfunction

      // one byte through the parser; returns 1 when it is a hostname byte
      function bit parse(int unsigned pos, logic [7:0] b, output int unsigned idx);
         int unsigned cap_eff;
         int unsigned k;
         cap_eff = (capacity > TSE_CAP_MAX) ? TSE_CAP_MAX : capacity;
         idx = 0;
         case (phase)
            PH_HEAD: begin
               if (pos == 0 && b != REC_HANDSHAKE) settle(ST_UNSUP, 5);
               else if (pos == 5 && b != HS_CLIENT_HELLO) settle(ST_UNSUP, 9);
               else if (pos >= 6 && pos <= 8) begin
                  acc = ((acc << 8) | b) & 24'hFFFFFF;
                  if (pos == 8 && acc > TSE_PACKET_CAP) settle(ST_MAL, 9);
               end else if (pos == 42) open_field(PH_SESSLEN, 1);
            end
            PH_SESSLEN: skip_or(b, PH_SESS, PH_CIPHLEN, 2);
            PH_SESS: begin
               remain--;
               if (remain == 0) open_field(PH_CIPHLEN, 2);
            end
            PH_CIPHLEN: begin
               acc = ((acc << 8) | b) & 16'hFFFF;
               remain--;
               if (remain == 0) skip_or(acc, PH_CIPH, PH_COMPLEN, 1);
            end
            PH_CIPH: begin
               remain--;
               if (remain == 0) open_field(PH_COMPLEN, 1);
            end
            PH_COMPLEN: skip_or(b, PH_COMP, PH_EXTSLEN, 2);
            PH_COMP: begin
               remain--;
               if (remain == 0) open_field(PH_EXTSLEN, 2);
            end
            PH_EXTSLEN: begin
               acc = ((acc << 8) | b) & 16'hFFFF;
               remain--;
               if (remain == 0) begin
                  if (acc > TSE_PACKET_CAP) settle(ST_MAL, pos + 1);
                  else begin
                     ext_end = (pos + 1 + acc) & 17'h1FFFF;
                     next_ext(pos + 1);
                  end
               end
            end
            PH_EXTHDR: begin
               acc = ((acc << 8) | b) & 16'hFFFF;
               remain--;
               if (remain == 2) begin
                  ext_type = acc;
                  acc = 0;
               end else if (remain == 0) begin
                  ext_len = acc;
                  if (pos + 1 + ext_len > ext_end) settle(ST_MAL, ext_end);
                  else if (ext_type == SNI_EXT_TYPE) begin
                     if (ext_len < 5) settle(ST_MAL, ext_end);
                     else open_field(PH_SNIHDR, 5);
                  end else if (ext_len == 0) next_ext(pos + 1);
                  else open_field(PH_EXTSKIP, ext_len);
               end
            end
            PH_EXTSKIP: begin
               remain--;
               if (remain == 0) next_ext(pos + 1);
            end
            PH_SNIHDR: begin
               k = 5 - remain;
               if (k == 2 && b != NAME_TYPE_HOST) settle(ST_MAL, ext_end);
               else begin
                  acc = ((acc << 8) | b) & 16'hFFFF;
                  remain--;
                  if (remain == 0) begin
                     if (5 + acc > ext_len || acc == 0 || acc >= cap_eff)
                        settle(ST_MAL, ext_end);
                     else begin
                        host_len = acc;
                        open_field(PH_NAME, acc);
                     end
                  end
               end
            end
            PH_NAME: begin
               idx = (host_len - remain) & 10'h3FF;
               remain--;
               if (remain == 0) begin
                  name_seen = 1;
                  settle(ST_OK, ext_end);
               end
               return 1;
            end
            default: ;
         endcase
         return 0;
      endfunction

      // accepted packet byte: work out what the block owes for it
      function void note_byte(tse_req_type r);
         tse_rsp_type  e;
         int unsigned  pos;
         int unsigned  idx;
         logic [1:0]   st;
         pos = byte_count;
         if (pos < TSE_PACKET_CAP && phase != PH_DONE) begin
            if (parse(pos, r.pkt_byte, idx)) begin
               e = '0;
               e.kind = KIND_NAME;
               e.name_byte = r.pkt_byte;
               e.name_index = idx[9:0];
               e.status = ST_OK;
               e.last_of_run = !r.end_of_packet;
               owed_q.push_back(e);
            end
         end
         if (byte_count <= TSE_PACKET_CAP) byte_count++;
         if (r.end_of_packet) begin
            if (capacity == 0 || byte_count > TSE_PACKET_CAP) st = ST_MAL;
            else if (phase == PH_DONE && byte_count >= err_needs) st = err_code;
            else st = ST_TRUNC;
            e = '0;
            e.kind = KIND_STATUS;
            e.status = st;
            e.name_length = (st == ST_OK && name_seen) ? host_len[9:0] : 10'd0;
            e.last_of_run = 1'b1;
            owed_q.push_back(e);
            clear_packet();
         end
      endfunction

      function void check_result(tse_rsp_type a);
         tse_rsp_type e;
         if (owed_q.size() == 0) begin
            $error("unexpected result kind=%0d status=%0d", a.kind, a.status);
            fails++;
            return;
         end
         e = owed_q.pop_front();
         checked++;
         if (a.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, a.kind); fails++;
         end
         if (a.name_byte !== e.name_byte) begin
            $error("name_byte: expected %0h, got %0h", e.name_byte, a.name_byte); fails++;
         end
         if (a.name_index !== e.name_index) begin
            $error("name_index: expected %0d, got %0d", e.name_index, a.name_index); fails++;
         end
         if (a.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, a.status); fails++;
         end
         if (a.name_length !== e.name_length) begin
            $error("name_length: expected %0d, got %0d", e.name_length, a.name_length);
            fails++;
         end
         if (a.last_of_run !== e.last_of_run) begin
            $error("last_of_run: expected %0d, got %0d", e.last_of_run, a.last_of_run);
            fails++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   tse_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   tse_rsp_type rsp_data;
   logic        csr_wr_en;
   logic [10:0] csr_wr_data;

   sni_scoreboard_type sb = new();
   logic [7:0]    pkt[$];
   bit            calm;        // long stretch with no idling on either side
   int            packets_sent;
   int            bytes_sent;

   tls_sni_extractor u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns clock
   always begin
      clock = 1'b1; #2;
      clock = 1'b0; #2;
   end

   // both channels are watched at the edge, before any of its updates land
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_byte(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // receiver stalls about a third of the time outside the calm stretch
   always @(posedge clock) begin
      rsp_stall <= !calm && ($urandom_range(0, 99) < 31);
   end

   function automatic void push16(ref logic [7:0] q[$], input int unsigned v);
      q.push_back(v[15:8]);
      q.push_back(v[7:0]);
   endfunction

   // client hello with random content; the adjust arguments bend lengths
   // sni_adj shifts the server-name extension length, tail adds unparsed bytes
   task automatic build_hello(int sess, int ciph, int comp, int n_pre, int host_chars,
                              bit with_sni, logic [7:0] name_type, int sni_adj, int tail);
      logic [7:0]  ext[$];
      int unsigned hs_len;
      int          len;
      pkt.delete();
      repeat (n_pre) begin
         push16(ext, $urandom_range(1, 16'hFFFF));
         len = $urandom_range(0, 6);
         push16(ext, len);
         repeat (len) ext.push_back($urandom_range(0, 255));
      end
      if (with_sni) begin
         push16(ext, SNI_EXT_TYPE);
         push16(ext, host_chars + 5 + sni_adj);
         push16(ext, host_chars + 3);
         ext.push_back(name_type);
         push16(ext, host_chars);
         repeat (host_chars) ext.push_back($urandom_range(0, 255));
      end
      repeat (tail) ext.push_back($urandom_range(0, 255));
      hs_len = 38 + sess + 2 + ciph + 1 + comp + 2 + ext.size();
      pkt.push_back(REC_HANDSHAKE);
      push16(pkt, 16'h0301);
      push16(pkt, hs_len + 4);
      pkt.push_back(HS_CLIENT_HELLO);
      pkt.push_back(8'h00);
      push16(pkt, hs_len);
      repeat (34) pkt.push_back($urandom_range(0, 255));   // version and random
      pkt.push_back(sess[7:0]);
      repeat (sess) pkt.push_back($urandom_range(0, 255));
      push16(pkt, ciph);
      repeat (ciph) pkt.push_back($urandom_range(0, 255));
      pkt.push_back(comp[7:0]);
      repeat (comp) pkt.push_back($urandom_range(0, 255));
      push16(pkt, ext.size());
      foreach (ext[i]) pkt.push_back(ext[i]);
   endtask

   task automatic build_clean(int host_chars);
      build_hello($urandom_range(0, 32), 2 * $urandom_range(0, 8), $urandom_range(0, 2),
                  $urandom_range(0, 3), host_chars, 1, NAME_TYPE_HOST, 0, 0);
   endtask

   // one byte, with random idle cycles ahead of it
   task automatic send_byte(logic [7:0] b, bit eop);
      while (!calm && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{pkt_byte: b, end_of_packet: eop};
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_packet();
      foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
      req_valid <= 1'b0;
      packets_sent++;
      bytes_sent += pkt.size();
   endtask

   // wait for every owed result, then wait out bytes still in flight
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // capacity writes only happen with the block idle
   task automatic write_capacity(logic [10:0] v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.capacity = v;
   endtask

   task automatic random_packet(int max_name);
      int pick;
      int cut;
      pick = $urandom_range(0, 99);
      build_clean($urandom_range(1, max_name));
      if (pick < 60) begin
         // clean hello
      end else if (pick < 72) begin
         cut = $urandom_range(1, pkt.size());
         while (pkt.size() > cut) void'(pkt.pop_back());
      end else if (pick < 82) begin
         pkt[$urandom_range(0, pkt.size() - 1)] = $urandom_range(0, 255);
      end else if (pick < 88) begin
         repeat ($urandom_range(1, 5)) pkt.push_back($urandom_range(0, 255));
      end else if (pick < 94) begin
         build_hello($urandom_range(0, 4), 2, 1, $urandom_range(0, 4), 0, 0,
                     NAME_TYPE_HOST, 0, $urandom_range(0, 3));
      end else if (pick < 97) begin
         // lengths pushed out of range
         pkt[$urandom_range(6, 8)] = $urandom_range(0, 255);
      end else begin
         pkt.delete();
         repeat ($urandom_range(1, 60)) pkt.push_back($urandom_range(0, 255));
      end
      send_packet();
   endtask

   initial begin
      int cycles;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      calm = 0;
      packets_sent = 0;
      bytes_sent = 0;
      reset <= 1'b1;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed packets at reset capacity
      build_clean(12); send_packet();
      build_hello(0, 2, 1, 0, 10, 1, NAME_TYPE_HOST, 0, 0);
      pkt[0] = 8'h17; send_packet();                           // wrong record type
      build_hello(0, 2, 1, 0, 10, 1, NAME_TYPE_HOST, 0, 0);
      pkt[5] = 8'h02; send_packet();                           // not a client hello
      build_hello(0, 2, 1, 0, 10, 1, NAME_TYPE_HOST, 0, 0);
      pkt[6] = 8'h01; send_packet();                           // handshake length over cap
      pkt.delete(); pkt.push_back(REC_HANDSHAKE); send_packet();   // single byte
      build_clean(20); repeat (10) void'(pkt.pop_back()); send_packet();   // cut in name
      build_hello(0, 0, 0, 2, 0, 0, NAME_TYPE_HOST, 0, 0); send_packet();  // no server name
      build_hello(0, 0, 0, 1, 0, 0, NAME_TYPE_HOST, 0, 3); send_packet();  // short tail
      build_hello(1, 2, 1, 0, 6, 1, NAME_TYPE_HOST, -2, 0); send_packet(); // sni too short
      build_hello(1, 2, 1, 0, 6, 1, 8'h01, 0, 0); send_packet();           // bad name type
      build_hello(0, 2, 1, 0, 0, 1, NAME_TYPE_HOST, 0, 0); send_packet();  // empty name
      build_hello(0, 2, 1, 1, 5, 1, NAME_TYPE_HOST, 0, 4); send_packet();  // trailing bytes
      build_hello(2, 2, 1, 0, 5, 1, NAME_TYPE_HOST, 0, 0);
      pkt[52] = 8'hFF; pkt[53] = 8'hFF; send_packet();         // extension block too long

      write_capacity(11'd30);                                  // name length at the limit
      build_hello(0, 2, 1, 0, 29, 1, NAME_TYPE_HOST, 0, 0); send_packet();
      build_hello(0, 2, 1, 0, 30, 1, NAME_TYPE_HOST, 0, 0); send_packet();
      write_capacity(11'd0);                                   // every packet malformed
      build_clean(5); send_packet();
      pkt.delete(); pkt.push_back(8'h00); send_packet();
      write_capacity(11'd1);
      build_clean(1); send_packet();

      // random phases with a few capacity settings
      write_capacity(TSE_CAP_RESET);
      repeat (2) random_packet(40);
      drain();                                                 // sender waits for all results
      calm = 1;
      repeat (2) random_packet(40);
      calm = 0;
      write_capacity(11'($urandom_range(2, 40)));
      random_packet(48);
      write_capacity(11'd2047);
      random_packet(60);

      cycles = 0;
      req_valid <= 1'b0;
      while (sb.owed_q.size() != 0 && cycles < 100000) begin
         @(posedge clock);
         cycles++;
      end
      repeat (20) @(posedge clock);
      if (sb.owed_q.size() != 0) begin
         $error("%0d results never arrived", sb.owed_q.size());
         sb.fails++;
      end
      $display("covered %0d packets, %0d bytes, %0d results checked", packets_sent,
               bytes_sent, sb.checked);
      $display("capacities 0, 1, 30, 256, a small random one and 2047; clean, cut, corrupted");
      if (sb.fails == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
